// ----- sv/hlt_pkg.sv -----
package hlt_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 10;
  localparam int unsigned TIME_CHARS     = 6;
  localparam int unsigned KEEP_BYTES     = TIME_CHARS + 1;
  localparam int unsigned KEEP_IW        = $clog2(KEEP_BYTES);
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [7:0] CR_BYTE    = 8'h0d;
  localparam logic [7:0] NUL_BYTE   = 8'h00;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;
  localparam logic [6:0] MAX_HOURS  = 7'd23;
  localparam logic [6:0] MAX_MINSEC = 7'd59;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [16:0] SEC_PER_MIN  = 17'd60;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_LENGTH = 3'd1,
    ST_DIGIT  = 3'd2,
    ST_RANGE  = 3'd3,
    ST_ZERO   = 3'd4
  } status_t;

  typedef struct packed {
    status_t         pre_status;
    logic [5:0][3:0] digits;
  } job_t;

  typedef struct packed {
    logic push;
    logic full;
  } q_wr_t;

  typedef struct packed {
    logic pop;
    logic valid;
  } q_rd_t;

endpackage

// ----- sv/hlt_if.sv -----
interface hlt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface hlt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [16:0] total_seconds;

  modport source (output valid, output status, output total_seconds, input ready);
  modport sink (input valid, input status, input total_seconds, output ready);
endinterface

// ----- sv/hlt_front.sv -----
module hlt_front #(
  parameter int unsigned LINE_DEPTH = hlt_pkg::LINE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  hlt_in_if.sink        in_ch,
  input  logic          q_full,
  output hlt_pkg::q_wr_t q_wr,
  output hlt_pkg::job_t  q_job
);

  localparam int unsigned PW = $clog2(LINE_DEPTH);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    store_r [hlt_pkg::KEEP_BYTES];
  logic          accept, is_cr;
  logic          all_nz, all_dig, len_ok;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_cr       = (in_ch.rx_byte == hlt_pkg::CR_BYTE);

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (is_cr || pos_r == PW'(LINE_DEPTH - 1)) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // only the first seven places are ever examined
  always_ff @(posedge clk) begin
    if (accept && !is_cr && pos_r < PW'(hlt_pkg::KEEP_BYTES)) begin
      store_r[pos_r[hlt_pkg::KEEP_IW-1:0]] <= in_ch.rx_byte;
    end
  end

  always_comb begin
    all_nz  = 1'b1;
    all_dig = 1'b1;
    for (int i = 0; i < hlt_pkg::TIME_CHARS; i++) begin
      if (store_r[i] == hlt_pkg::NUL_BYTE) all_nz = 1'b0;
      if (!(store_r[i] inside {[hlt_pkg::DIGIT_LO:hlt_pkg::DIGIT_HI]})) all_dig = 1'b0;
      q_job.digits[5-i] = store_r[i][3:0];
    end
    len_ok = (pos_r >= PW'(hlt_pkg::TIME_CHARS)) && all_nz &&
             ((pos_r == PW'(hlt_pkg::TIME_CHARS)) ||
              (store_r[hlt_pkg::TIME_CHARS] == hlt_pkg::NUL_BYTE));
    if (!len_ok) begin
      q_job.pre_status = hlt_pkg::ST_LENGTH;
    end else if (!all_dig) begin
      q_job.pre_status = hlt_pkg::ST_DIGIT;
    end else begin
      q_job.pre_status = hlt_pkg::ST_OK;
    end
  end

  assign q_wr.push = accept && is_cr;
  assign q_wr.full = q_full;

endmodule

// ----- sv/hlt_queue.sv -----
module hlt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  hlt_pkg::q_wr_t wr,
  input  hlt_pkg::job_t  wr_job,
  output logic           full,
  input  logic           pop,
  output hlt_pkg::q_rd_t rd,
  output hlt_pkg::job_t  rd_job
);

  localparam int unsigned AW = $clog2(hlt_pkg::QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(hlt_pkg::QUEUE_DEPTH + 1);

  hlt_pkg::job_t mem_r [hlt_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(hlt_pkg::QUEUE_DEPTH));
  assign do_push = wr.push && !wr.full;
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wp_r <= (wp_r == AW'(hlt_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (do_pop)  rp_r <= (rp_r == AW'(hlt_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wr_job;
  end

  assign rd.valid = (cnt_r != '0);
  assign rd.pop   = do_pop;
  assign rd_job   = mem_r[rp_r];

endmodule

// ----- sv/hlt_back.sv -----
module hlt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  hlt_pkg::q_rd_t q_rd,
  input  hlt_pkg::job_t  job,
  output logic           pop,
  hlt_out_if.source      out_ch
);

  logic [6:0]       hh, mm, ss;
  logic [16:0]      total;
  hlt_pkg::status_t st;
  logic [16:0]      secs;
  logic             valid_r;
  hlt_pkg::status_t status_r;
  logic [16:0]      secs_r;

  always_comb begin
    hh    = 7'(7'(job.digits[5]) * 7'd10) + 7'(job.digits[4]);
    mm    = 7'(7'(job.digits[3]) * 7'd10) + 7'(job.digits[2]);
    ss    = 7'(7'(job.digits[1]) * 7'd10) + 7'(job.digits[0]);
    total = 17'(17'(hh) * hlt_pkg::SEC_PER_HOUR) + 17'(17'(mm) * hlt_pkg::SEC_PER_MIN)
          + 17'(ss);
    secs  = '0;
    if (job.pre_status != hlt_pkg::ST_OK) begin
      st = job.pre_status;
    end else if (hh > hlt_pkg::MAX_HOURS || mm > hlt_pkg::MAX_MINSEC ||
                 ss > hlt_pkg::MAX_MINSEC) begin
      st = hlt_pkg::ST_RANGE;
    end else if (total == '0) begin
      st = hlt_pkg::ST_ZERO;
    end else begin
      st   = hlt_pkg::ST_OK;
      secs = total;
    end
  end

  assign pop = q_rd.valid && (!valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_rd.pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= st;
      secs_r   <= secs;
    end
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.total_seconds = secs_r;

endmodule

// ----- sv/hhmmss_line_time_parser.sv -----
// hhmmss line time parser
// in_ch carries one received byte per beat; a carriage return closes the line
// and produces exactly one result beat on out_ch (status, total_seconds).
// other bytes are stored at line positions below seven and produce no result.
// throughput: one input beat per cycle, sustained, including back-to-back
// carriage returns; in_ch.ready drops only when the two-entry job queue
// between the byte front end and the time evaluator is full.
// a carriage return's job is written into the job queue, then moved into the
// output register that drives out_ch.
// the output register holds a result while out_ch.ready is low; the queue
// keeps taking lines until it fills, then in_ch.ready goes low.
// reset (rst_n low, synchronous) clears the line position, empties the queue
// and drops out_ch.valid; no clearing pass is needed.
module hhmmss_line_time_parser #(
  parameter int unsigned LINE_DEPTH = hlt_pkg::LINE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  hlt_in_if.sink    in_ch,
  hlt_out_if.source out_ch
);

  hlt_pkg::q_wr_t q_wr;
  hlt_pkg::q_rd_t q_rd;
  hlt_pkg::job_t  wr_job, rd_job;
  logic           q_full, q_pop;

  hlt_front #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr),
    .q_job  (wr_job)
  );

  hlt_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd     (q_rd),
    .rd_job (rd_job)
  );

  hlt_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .job    (rd_job),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule
